### src/fast_packet_reassembler_macros.svh
// Assertion helpers used by the reassembler datapath (fpr_dpath.sv)
`ifndef FAST_PACKET_REASSEMBLER_MACROS_SVH
`define FAST_PACKET_REASSEMBLER_MACROS_SVH

// Same-cycle implication
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/fpr_pkg.sv
`default_nettype none
package fpr_pkg;

   localparam int SLOTS       = 10;
   localparam int MAX_PAYLOAD = 223;
   localparam int WORDS       = (MAX_PAYLOAD + 7) / 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RAM_DEPTH   = SLOTS * WORDS;
   localparam int RAM_AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   localparam int ID_W    = 29;
   localparam int DATA_W  = 64;
   localparam int PGN_W   = 17;
   localparam int SIZE_W  = 8;
   localparam int SRC_W   = 8;
   localparam int WIDX_W  = 5;
   localparam int CSR_IDX_W = 4;
   localparam int LANES   = 8;

   localparam logic [PGN_W-1:0]  PGN_RESET  = 17'h1F805;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd47;
   localparam logic [SIZE_W-1:0] MIN_SIZE   = 8'd9;
   localparam logic [8:0]        PDU2_FIRST = 9'd240;
   localparam logic [PGN_W-1:0]  PDU1_MASK  = 17'h1FF00;
   localparam logic [SIZE_W-1:0] HEAD_COUNT = 8'd6;

   localparam logic [CSR_IDX_W-1:0] REG_WATCH_PGN  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WATCH_SIZE = 4'd1;

   typedef struct packed {
      logic load;     // capture the frame
      logic sel;      // latch the slot to work on
      logic open;     // claim a free slot
      logic wrst;     // zero the word counter
      logic clr;      // write a zero word
      logic head;     // write the six head bytes
      logic body;     // write a continuation frame
      logic free;     // release the slot
      logic set_cnt;  // store the new byte count
      logic rd;       // read a payload word out
   } fpr_cmd_type;

   typedef struct packed {
      logic keep;
      logic hit;
      logic free_any;
      logic seq_zero;
      logic beyond;
      logic complete;
      logic over;
      logic clr_last;
      logic rd_last;
      logic pipe_busy;
   } fpr_stat_type;

endpackage
`default_nettype wire

### src/fpr_ram.sv
`default_nettype none
module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### src/fpr_ctrl.sv
`default_nettype none
module fpr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire fpr_pkg::fpr_stat_type stat,
   output fpr_pkg::fpr_cmd_type      cmd
);
   import fpr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_CLEAR, S_HEAD, S_BODY, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      busy = (state_ff != S_IDLE) || stat.pipe_busy;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.sel  = 1'b1;
            cmd.wrst = 1'b1;
            if (!stat.keep) begin
               state_in = S_IDLE;
            end else if (stat.hit) begin
               state_in = stat.seq_zero ? S_HEAD : S_BODY;
            end else if (stat.free_any) begin
               cmd.open = 1'b1;
               state_in = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head = 1'b1;
            state_in = S_IDLE;
         end
         S_BODY: begin
            cmd.wrst = 1'b1;
            state_in = S_IDLE;
            if (stat.beyond) begin
               cmd.free = 1'b1;
            end else begin
               cmd.body = 1'b1;
               if (stat.complete) begin
                  cmd.free    = 1'b1;
                  cmd.set_cnt = 1'b1;
                  state_in    = S_EMIT;
               end else if (stat.over) begin
                  cmd.free = 1'b1;
               end else begin
                  cmd.set_cnt = 1'b1;
               end
            end
         end
         S_EMIT: begin
            cmd.rd = 1'b1;
            if (stat.rd_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### src/fpr_dpath.sv
`default_nettype none
`include "fast_packet_reassembler_macros.svh"
module fpr_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fpr_pkg::fpr_cmd_type              cmd,
   output fpr_pkg::fpr_stat_type                  stat,
   input  wire logic [fpr_pkg::ID_W-1:0]          req_can_id,
   input  wire logic [fpr_pkg::DATA_W-1:0]        req_frame_data,
   input  wire logic                              csr_we,
   input  wire logic [fpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fpr_pkg::PGN_W-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   output logic [fpr_pkg::SRC_W-1:0]              rsp_sender,
   output logic [fpr_pkg::WIDX_W-1:0]             rsp_word_index,
   output logic [fpr_pkg::DATA_W-1:0]             rsp_payload_word,
   output logic                                   rsp_last_word
);
   import fpr_pkg::*;

   logic [PGN_W-1:0]  watch_pgn_ff;
   logic [SIZE_W-1:0] watch_size_ff;
   logic [ID_W-1:0]   id_ff;
   logic [DATA_W-1:0] data_ff;

   logic              slot_busy_ff   [SLOTS];
   logic [SRC_W-1:0]  slot_sender_ff [SLOTS];
   logic [SIZE_W-1:0] slot_count_ff  [SLOTS];
   logic [SLOT_W-1:0] slot_ff;
   logic [WIDX_W-1:0] wcnt_ff;

   logic              rd_vld_ff, rd_last_ff;
   logic [WIDX_W-1:0] rd_idx_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [WIDX_W-1:0] rsp_idx_ff;
   logic [SRC_W-1:0]  rsp_sender_ff;
   logic [DATA_W-1:0] rsp_word_ff, rsp_word_in;

   logic [PGN_W-1:0]  pgn;
   logic [SRC_W-1:0]  src;
   logic [4:0]        seq;
   logic [SIZE_W-1:0] seqm1, pos, rem;
   logic [2:0]        n;
   logic [SIZE_W:0]   cnt;
   logic [WIDX_W-1:0] words;
   logic              hit, free_any;
   logic [SLOT_W-1:0] hit_idx, free_idx;

   logic              lane_we   [LANES];
   logic [RAM_AW-1:0] lane_wa   [LANES];
   logic [7:0]        lane_wd   [LANES];
   logic [7:0]        lane_rd   [LANES];
   logic [RAM_AW-1:0] rd_addr, slot_base;
   logic [2:0]        off;
   logic [SIZE_W-1:0] psum;

   // Frame decode
   always_comb begin
      pgn = id_ff[24:8];
      if (pgn[16:8] < PDU2_FIRST) begin
         pgn = pgn & PDU1_MASK;
      end
      src   = id_ff[SRC_W-1:0];
      seq   = data_ff[4:0];
      seqm1 = SIZE_W'(seq) - 8'd1;
      pos   = (seqm1 << 3) - seqm1 + HEAD_COUNT;
      rem   = watch_size_ff - pos;
      n     = (rem > 8'd7) ? 3'd7 : rem[2:0];
      cnt   = {1'b0, slot_count_ff[slot_ff]} + (SIZE_W+1)'(n);
      words = WIDX_W'(((SIZE_W+1)'(watch_size_ff) + 9'd7) >> 3);
   end

   // Slot search, lowest index wins
   always_comb begin
      hit      = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (slot_busy_ff[s] && slot_sender_ff[s] == src) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(s);
         end
         if (!slot_busy_ff[s]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      stat.keep      = (pgn == watch_pgn_ff) && (watch_size_ff >= MIN_SIZE) &&
                       ((SIZE_W+1)'(watch_size_ff) <= (SIZE_W+1)'(MAX_PAYLOAD));
      stat.hit       = hit;
      stat.free_any  = free_any;
      stat.seq_zero  = (seq == 5'd0);
      stat.beyond    = (pos >= watch_size_ff);
      stat.complete  = (cnt == {1'b0, watch_size_ff});
      stat.over      = (cnt > {1'b0, watch_size_ff});
      stat.clr_last  = (wcnt_ff == WIDX_W'(WORDS - 1));
      stat.rd_last   = (wcnt_ff == words - 5'd1);
      stat.pipe_busy = rd_vld_ff || rsp_valid_ff;
   end

   // Byte-lane write ports
   always_comb begin
      slot_base = RAM_AW'(slot_ff) * RAM_AW'(WORDS);
      rd_addr   = slot_base + RAM_AW'(wcnt_ff);
      off       = '0;
      psum      = '0;
      for (int b = 0; b < LANES; b++) begin
         lane_we[b] = 1'b0;
         lane_wa[b] = rd_addr;
         lane_wd[b] = '0;
         if (cmd.clr) begin
            lane_we[b] = 1'b1;
         end else if (cmd.head) begin
            lane_wa[b] = slot_base;
            if (b < 6) begin
               lane_we[b] = 1'b1;
               lane_wd[b] = data_ff[8*((b+2)%LANES) +: 8];
            end
         end else if (cmd.body) begin
            off        = 3'(b) - pos[2:0];
            psum       = pos + SIZE_W'(off);
            lane_we[b] = (off < n);
            lane_wa[b] = slot_base + RAM_AW'(psum[7:3]);
            lane_wd[b] = data_ff[{off + 3'd1, 3'b000} +: 8];
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fpr_ram #(
         .WIDTH (8),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .wr_addr (lane_wa[g]),
         .wr_data (lane_wd[g]),
         .rd_addr (rd_addr),
         .rd_data (lane_rd[g])
      );
   end

   // Zero bytes past the message end
   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         rsp_word_in[8*b +: 8] =
            ({rd_idx_ff, 3'(b)} < watch_size_ff) ? lane_rd[b] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         watch_pgn_ff  <= PGN_RESET;
         watch_size_ff <= SIZE_RESET;
         for (int s = 0; s < SLOTS; s++) begin
            slot_busy_ff[s] <= 1'b0;
         end
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_WATCH_PGN) begin
            watch_pgn_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_WATCH_SIZE) begin
            watch_size_ff <= csr_wdata[SIZE_W-1:0];
         end
         if (cmd.open) begin
            slot_busy_ff[free_idx] <= 1'b1;
         end
         if (cmd.free) begin
            slot_busy_ff[slot_ff] <= 1'b0;
         end
         rd_vld_ff    <= cmd.rd;
         rsp_valid_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff   <= req_can_id;
         data_ff <= req_frame_data;
      end
      if (cmd.sel) begin
         slot_ff <= hit ? hit_idx : free_idx;
      end
      if (cmd.open) begin
         slot_sender_ff[free_idx] <= src;
      end
      if (cmd.head) begin
         slot_count_ff[slot_ff] <= HEAD_COUNT;
      end
      if (cmd.set_cnt) begin
         slot_count_ff[slot_ff] <= cnt[SIZE_W-1:0];
      end
      if (cmd.wrst) begin
         wcnt_ff <= '0;
      end else if (cmd.clr || cmd.rd) begin
         wcnt_ff <= wcnt_ff + 5'd1;
      end
      rd_idx_ff     <= wcnt_ff;
      rd_last_ff    <= stat.rd_last;
      rsp_idx_ff    <= rd_idx_ff;
      rsp_last_ff   <= rd_last_ff;
      rsp_sender_ff <= src;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sender       = rsp_sender_ff;
   assign rsp_word_index   = rsp_idx_ff;
   assign rsp_payload_word = rsp_word_ff;
   assign rsp_last_word    = rsp_last_ff;

   `FPR_ASSERT_NOW(a_no_load_in_burst, cmd.load, !rsp_valid_ff && !rd_vld_ff, "frame taken during burst")
   `FPR_ASSERT_NOW(a_last_index, rsp_valid_ff && rsp_last_ff, rsp_idx_ff == words - 5'd1, "last word index wrong")
   `FPR_ASSERT_NEXT(a_freed_before_read, cmd.free && cmd.set_cnt, !slot_busy_ff[slot_ff], "slot not freed")
endmodule
`default_nettype wire

### src/fast_packet_reassembler.sv
// Channel     | Handshake            | Contents
// request     | start / busy         | req_can_id, req_frame_data
// response    | rsp_valid (strobe)   | rsp_sender, rsp_word_index, rsp_payload_word, rsp_last_word
// register    | csr_valid / csr_ready| csr_index, csr_wdata
//
// A filtered-out frame passes through IDLE and DECIDE; a continuation or restart frame adds
// BODY or HEAD; one that opens a slot zeros its 28 payload words in CLEAR, one per cycle, then
// does HEAD. A completing frame reads its words out in EMIT, one per cycle, via the RAM read and
// response registers; busy stays high until the last word has been strobed. Results cannot be stalled.
// Reset is synchronous: all slots free, registers to their defaults; csr_ready is always high.
`default_nettype none
module fast_packet_reassembler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fpr_pkg::ID_W-1:0]      req_can_id,
   input  wire logic [fpr_pkg::DATA_W-1:0]    req_frame_data,
   output logic                               rsp_valid,
   output logic [fpr_pkg::SRC_W-1:0]          rsp_sender,
   output logic [fpr_pkg::WIDX_W-1:0]         rsp_word_index,
   output logic [fpr_pkg::DATA_W-1:0]         rsp_payload_word,
   output logic                               rsp_last_word,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fpr_pkg::PGN_W-1:0]     csr_wdata
);
   import fpr_pkg::*;

   fpr_cmd_type  cmd;
   fpr_stat_type stat;

   assign csr_ready = 1'b1;

   fpr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fpr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_can_id       (req_can_id),
      .req_frame_data   (req_frame_data),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_sender       (rsp_sender),
      .rsp_word_index   (rsp_word_index),
      .rsp_payload_word (rsp_payload_word),
      .rsp_last_word    (rsp_last_word)
   );
endmodule
`default_nettype wire

### dv/fast_packet_reassembler_tb.sv
`default_nettype none
module fast_packet_reassembler_tb;
   import fpr_pkg::*;

   localparam int LIMIT   = 400000;
   localparam int SETTLE  = 48;
   localparam int NSRC    = 12;
   localparam int NPHASES = 8;

   typedef struct {
      logic [SRC_W-1:0]  sender;
      logic [WIDX_W-1:0] index;
      logic [DATA_W-1:0] word;
      logic              last;
   } word_type;

   typedef struct {
      logic [ID_W-1:0]   can_id;
      logic [DATA_W-1:0] data;
      int                n_words;   // -1: left to the predictor
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ID_W-1:0]   req_can_id = '0;
   logic [DATA_W-1:0] req_frame_data = '0;
   logic rsp_valid;
   logic [SRC_W-1:0]  rsp_sender;
   logic [WIDX_W-1:0] rsp_word_index;
   logic [DATA_W-1:0] rsp_payload_word;
   logic rsp_last_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PGN_W-1:0]     csr_wdata = '0;

   fast_packet_reassembler u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [PGN_W-1:0]  pgn_reg;
   logic [SIZE_W-1:0] size_reg;
   bit                slot_open [SLOTS];
   logic [7:0]        slot_src  [SLOTS];
   int                slot_fill [SLOTS];
   logic [7:0]        slot_bytes[SLOTS][MAX_PAYLOAD];

   word_type pending_words[$];
   int    errors = 0;
   int    cycles = 0;

   function automatic logic [7:0] byte_of(logic [DATA_W-1:0] d, int k);
      return d[8*k +: 8];
   endfunction

   function automatic int reassemble(logic [ID_W-1:0] id, logic [DATA_W-1:0] d);
      logic [PGN_W-1:0] pgn;
      logic [7:0] src;
      int size, s, seq, pos, n, cnt, words;
      word_type w;
      pgn  = id[24:8];
      src  = id[7:0];
      size = size_reg;
      if (pgn[16:8] < PDU2_FIRST) pgn = pgn & PDU1_MASK;
      if (pgn != pgn_reg || size < MIN_SIZE || size > MAX_PAYLOAD) return 0;
      for (s = 0; s < SLOTS; s++)
         if (slot_open[s] && slot_src[s] == src) break;
      if (s < SLOTS) begin
         seq = byte_of(d, 0) & 8'h1F;
         if (seq == 0) begin
            slot_fill[s] = HEAD_COUNT;
            for (int k = 0; k < 6; k++) slot_bytes[s][k] = byte_of(d, k + 2);
            return 0;
         end
         pos = (seq - 1) * 7 + 6;
         if (pos >= size) begin
            slot_open[s] = 0;
            return 0;
         end
         n = (size - pos > 7) ? 7 : size - pos;
         for (int k = 0; k < n; k++) slot_bytes[s][pos + k] = byte_of(d, k + 1);
         cnt = slot_fill[s] + n;
         if (cnt > size) begin
            slot_open[s] = 0;
            return 0;
         end
         slot_fill[s] = cnt;
         if (cnt < size) return 0;
         slot_open[s] = 0;
         words = (size + 7) / 8;
         for (int i = 0; i < words; i++) begin
            w.sender = slot_src[s];
            w.index  = i[WIDX_W-1:0];
            w.word   = '0;
            for (int b = 0; b < 8; b++)
               if (i * 8 + b < size) w.word[8*b +: 8] = slot_bytes[s][i * 8 + b];
            w.last = (i + 1 == words);
            pending_words.push_back(w);
         end
         return words;
      end
      for (s = 0; s < SLOTS; s++)
         if (!slot_open[s]) break;
      if (s >= SLOTS) return 0;
      slot_open[s] = 1;
      slot_src[s]  = src;
      slot_fill[s] = HEAD_COUNT;
      for (int k = 0; k < MAX_PAYLOAD; k++) slot_bytes[s][k] = 8'h00;
      for (int k = 0; k < 6; k++) slot_bytes[s][k] = byte_of(d, k + 2);
      return 0;
   endfunction

   // check each strobed word against the oldest expectation
   always @(posedge clock) begin
      word_type w;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word sender %h index %0d data %h last %b", $time,
                     rsp_sender, rsp_word_index, rsp_payload_word, rsp_last_word);
            errors++;
         end else begin
            w = pending_words.pop_front();
            if (w.sender !== rsp_sender) begin
               $display("%0t: sender exp %h got %h", $time, w.sender, rsp_sender);
               errors++;
            end
            if (w.index !== rsp_word_index) begin
               $display("%0t: word_index exp %0d got %0d", $time, w.index, rsp_word_index);
               errors++;
            end
            if (w.word !== rsp_payload_word) begin
               $display("%0t: payload_word exp %h got %h", $time, w.word, rsp_payload_word);
               errors++;
            end
            if (w.last !== rsp_last_word) begin
               $display("%0t: last_word exp %b got %b", $time, w.last, rsp_last_word);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [ID_W-1:0] make_id(logic [3:0] pri, logic [16:0] pgn,
                                               logic [7:0] src);
      return {pri, pgn, src};
   endfunction

   // hold the frame until the block takes it; start stays high on return
   task automatic send_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] d, int n_words);
      int got;
      start          <= 1'b1;
      req_can_id     <= id;
      req_frame_data <= d;
      do @(posedge clock); while (busy);
      got = reassemble(id, d);
      if (n_words >= 0 && got != n_words) begin
         $display("%0t: words for frame %h exp %0d got %0d", $time, id, n_words, got);
         errors++;
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [PGN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WATCH_PGN) pgn_reg = value;
      else size_reg = value[SIZE_W-1:0];
      @(posedge clock);
   endtask

   task automatic maybe_idle(int n);
      // hold off in roughly 28 of 100 transactions, none in a middle stretch
      if ((n < 100 || n > 170) && $urandom_range(99) < 28) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   frame_row_type directed[$];
   logic [16:0] phase_pgn [NPHASES] = '{17'h1F805, 17'h1F805, 17'h0EA00, 17'h1FFFF,
                                        17'h00000, 17'h1FFFF, 17'h1F805, 17'h1F805};
   int          phase_size[NPHASES] = '{47, 9, 223, 8, 255, 0, 20, 33};
   int          phase_len [NPHASES] = '{60, 50, 70, 12, 12, 8, 40, 40};
   logic [7:0]  stream_src[NSRC];
   int          stream_seq[NSRC];

   initial begin
      logic [DATA_W-1:0] d;
      logic [16:0] pgn;
      int item, last_seq, i;
      pgn_reg  = PGN_RESET;
      size_reg = SIZE_RESET;
      for (int s = 0; s < SLOTS; s++) slot_open[s] = 0;

      // filtered out, then a full message of all-ones bytes from 0xFF
      directed.push_back('{make_id(4'hF, 17'h00000, 8'h01), '1, 0});
      for (int q = 0; q < 7; q++)
         directed.push_back('{make_id(4'h0, 17'h1F805, 8'hFF),
                              {56'hFF_FFFF_FFFF_FFFF, 8'hE0 | q[7:0]}, (q == 6) ? 6 : 0});
      // open by a middle frame, drop beyond the end, reopen, restart, complete
      directed.push_back('{make_id(4'h5, 17'h1F805, 8'h00), {56'h0, 8'h03}, 0});
      directed.push_back('{make_id(4'h5, 17'h1F805, 8'h00), {56'h0, 8'h07}, 0});
      directed.push_back('{make_id(4'h5, 17'h1F805, 8'h00), {56'hA5A5A5A5_5A5A5A, 8'h05}, 0});
      for (int q = 0; q < 7; q++)
         directed.push_back('{make_id(4'hA, 17'h1F805, 8'h00),
                              {$urandom, $urandom} & ~64'h1F | q, -1});
      // destination byte on a PDU2 PGN is not masked: no match
      directed.push_back('{make_id(4'h1, 17'h1F8FF, 8'h42), '0, 0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r]) begin
         send_frame(directed[r].can_id, directed[r].data, directed[r].n_words);
         maybe_idle(0);
      end

      for (int s = 0; s < NSRC; s++) begin
         stream_src[s] = 8'($urandom);
         stream_seq[s] = 0;
      end
      item = 0;
      for (int ph = 0; ph < NPHASES; ph++) begin
         settle();
         pgn = (ph == 6) ? 17'($urandom) : phase_pgn[ph];
         write_reg(REG_WATCH_PGN, pgn);
         write_reg(REG_WATCH_SIZE, PGN_W'(phase_size[ph]));
         last_seq = (phase_size[ph] > 6) ? (phase_size[ph] - 6 + 6) / 7 : 1;
         for (int n = 0; n < phase_len[ph]; n++) begin
            d = {$urandom, $urandom};
            if ($urandom_range(99) < 12) begin
               send_frame(29'($urandom), d, -1);
            end else begin
               i = $urandom_range(NSRC - 1);
               if ($urandom_range(99) < 8) d[4:0] = 5'($urandom_range(31));
               else d[4:0] = 5'(stream_seq[i]);
               stream_seq[i] = (stream_seq[i] >= last_seq) ? 0 : stream_seq[i] + 1;
               send_frame(make_id(4'($urandom), (pgn[16:8] < PDU2_FIRST) ?
                                  pgn | 17'($urandom_range(255)) : pgn, stream_src[i]),
                          d, -1);
            end
            item++;
            maybe_idle(item);
         end
      end

      settle();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
